// File: rtl/word_frequency_tally_table_unit_macros.svh
// Assertion helpers for the word tally block.
// Each expects clk and rst_n in scope.
`ifndef WORD_FREQUENCY_TALLY_TABLE_UNIT_MACROS_SVH
`define WORD_FREQUENCY_TALLY_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define WFTT_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wftt: same-cycle check failed");

// next-cycle implication
`define WFTT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wftt: next-cycle check failed");

`endif

// File: rtl/wftt_pkg.sv
`timescale 1ns / 1ps
package wftt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int WORD_LEN    = 32;

    localparam int CH_W   = 8;
    localparam int POS_W  = 8;
    localparam int CNT_W  = 32;
    localparam int ENT_W  = $clog2(TABLE_DEPTH + 1);  // fill count, holds TABLE_DEPTH
    localparam int IDX_W  = $clog2(TABLE_DEPTH);      // table index
    localparam int LEN_W  = $clog2(WORD_LEN + 1);     // buffer length, holds WORD_LEN
    localparam int BIDX_W = $clog2(WORD_LEN);         // byte index in the buffer
    localparam int WORD_W = WORD_LEN * CH_W;

    typedef logic [WORD_LEN-1:0][CH_W-1:0] word_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] position;
        count_t           count;
        logic             is_new;
        logic             stopped;
        logic             truncated;
    } result_t;

endpackage

// File: rtl/word_frequency_tally_table_unit.sv
`timescale 1ns / 1ps
// Word frequency tally: a word arrives one character per item on the slave
// stream (tdata = character, tlast = final character of the word). On the
// final character the table of stored words is searched from entry 0 for an
// equal word; a hit bumps that entry's count (saturating), a miss appends the
// word with count 1. One result item per word leaves on the master stream:
// tdata = {count, position}, tuser = {truncated, stopped, is_new}.
// Characters past WORD_LEN are dropped and the word is flagged truncated.
// Once TABLE_DEPTH entries are filled, further words are reported as stopped.
// Flow: characters that are not last are taken while idle. A last
// character is accepted, then the stored entries are compared in order (the
// shared word comparator reads one table row per cycle from the word RAM);
// a hit then reads the count RAM and writes the bumped count, a miss appends.
// The input is not ready while a word is being looked up.
// Reset clears the character buffer and the fill count; no RAM sweep is
// needed since only filled entries are ever read.
// A stalled receiver holds the result in the output register; characters of
// the next word are still taken; its search runs, its update waits for the slot.
module word_frequency_tally_table_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] ch
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata,   // [7:0] position, [39:8] count
    output logic [2:0]               m_tuser    // [0] is_new, [1] stopped, [2] truncated
);
    import wftt_pkg::*;
    `include "word_frequency_tally_table_unit_macros.svh"

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // taking characters
    localparam logic [2:0] ST_SEARCH = 3'd1;  // one stored word compared per cycle
    localparam logic [2:0] ST_CNT_RD = 3'd2;  // count read in flight
    localparam logic [2:0] ST_CNT_WR = 3'd3;  // count bump and result
    localparam logic [2:0] ST_APPEND = 3'd4;  // new entry
    localparam logic [2:0] ST_STOP   = 3'd5;  // table full

    logic [2:0]       state_reg, state_next;
    word_t            buf_reg, buf_next;
    logic [LEN_W-1:0] blen_reg, blen_next;
    logic             ovf_reg, ovf_next;
    logic [ENT_W-1:0] entry_reg, entry_next;
    logic [ENT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             s_acc;
    logic             proceed;
    logic             hit;
    word_t            wram_rdata;
    logic             wram_we;
    count_t           cram_rdata;
    count_t           cram_wdata;
    logic [IDX_W-1:0] cram_waddr;
    logic             cram_we;
    count_t           cnt_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    // result slot is free, or frees up this cycle
    assign proceed  = !out_valid_reg || m_tready;
    // shared word comparator
    assign hit      = pend_reg && (wram_rdata == buf_reg);
    assign cnt_inc  = (cram_rdata == COUNT_MAX) ? cram_rdata : cram_rdata + count_t'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.count, out_reg.position};
    assign m_tuser  = {out_reg.truncated, out_reg.stopped, out_reg.is_new};

    wftt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_word_ram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (entry_reg[IDX_W-1:0]),
        .wdata (buf_reg),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (wram_rdata)
    );

    wftt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cram_waddr),
        .wdata (cram_wdata),
        .raddr (hit_idx_reg),
        .rdata (cram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        blen_next      = blen_reg;
        ovf_next       = ovf_reg;
        entry_next     = entry_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        hit_idx_next   = hit_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        wram_we        = 1'b0;
        cram_we        = 1'b0;
        cram_waddr     = hit_idx_reg;
        cram_wdata     = cnt_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (blen_reg < LEN_W'(WORD_LEN))
                    begin
                        buf_next[blen_reg[BIDX_W-1:0]] = s_tdata;
                        blen_next = blen_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        if (entry_reg >= ENT_W'(TABLE_DEPTH))
                        begin
                            state_next = ST_STOP;
                        end
                        else if (entry_reg == '0)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (hit)
                begin
                    hit_idx_next = cmp_idx_reg;
                    state_next   = ST_CNT_RD;
                end
                else if (rd_idx_reg < entry_reg)
                begin
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                    rd_idx_next  = rd_idx_reg + ENT_W'(1);
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_CNT_RD:
            begin
                state_next = ST_CNT_WR;
            end

            ST_CNT_WR:
            begin
                if (proceed)
                begin
                    cram_we            = 1'b1;
                    out_next.position  = POS_W'(hit_idx_reg);
                    out_next.count     = cnt_inc;
                    out_next.is_new    = 1'b0;
                    out_next.stopped   = 1'b0;
                    out_next.truncated = ovf_reg;
                    out_valid_next     = 1'b1;
                    buf_next           = '0;
                    blen_next          = '0;
                    ovf_next           = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            ST_APPEND:
            begin
                cram_waddr = entry_reg[IDX_W-1:0];
                cram_wdata = count_t'(1);
                if (proceed)
                begin
                    wram_we            = 1'b1;
                    cram_we            = 1'b1;
                    out_next.position  = POS_W'(entry_reg[IDX_W-1:0]);
                    out_next.count     = count_t'(1);
                    out_next.is_new    = 1'b1;
                    out_next.stopped   = 1'b0;
                    out_next.truncated = ovf_reg;
                    out_valid_next     = 1'b1;
                    entry_next         = entry_reg + ENT_W'(1);
                    buf_next           = '0;
                    blen_next          = '0;
                    ovf_next           = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            ST_STOP:
            begin
                if (proceed)
                begin
                    out_next.position  = '0;
                    out_next.count     = '0;
                    out_next.is_new    = 1'b0;
                    out_next.stopped   = 1'b1;
                    out_next.truncated = ovf_reg;
                    out_valid_next     = 1'b1;
                    buf_next           = '0;
                    blen_next          = '0;
                    ovf_next           = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_reg       <= '0;
            blen_reg      <= '0;
            ovf_reg       <= 1'b0;
            entry_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            blen_reg      <= blen_next;
            ovf_reg       <= ovf_next;
            entry_reg     <= entry_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        out_reg     <= out_next;
    end

    `WFTT_ASSERT_IMPL(a_stop_empty, m_tvalid && m_tuser[1], m_tdata[39:8] == '0 && !m_tuser[0])
    `WFTT_ASSERT_IMPL(a_new_is_one, out_valid_reg && out_reg.is_new, out_reg.count == count_t'(1))
    `WFTT_ASSERT_IMPL(a_fill_bound, 1'b1, entry_reg <= ENT_W'(TABLE_DEPTH))
    `WFTT_ASSERT_NEXT(a_append_grows, wram_we, entry_reg == $past(entry_reg) + ENT_W'(1))

endmodule

// File: rtl/wftt_ram.sv
`timescale 1ns / 1ps
module wftt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/word_tally_checker.sv
`timescale 1ns / 1ps
module word_tally_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [7:0] position, [39:8] count
    input  logic [2:0]  m_tuser,    // [0] is_new, [1] stopped, [2] truncated
    output int          errors,
    output int          pending
);
    import wftt_pkg::*;

    // word being collected, zero padded
    word_t   cur_word;
    int      cur_len;
    logic    cur_clipped;

    // tally table
    word_t   table_words  [TABLE_DEPTH];
    count_t  table_counts [TABLE_DEPTH];
    int      table_fill;

    result_t expected_tallies [$];

    task automatic flag_field(input string name, input logic [39:0] want, input logic [39:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    // One character in; on the word end, look the word up and queue its tally.
    task automatic take_char(input logic [7:0] ch, input logic last);
        result_t r;
        int      hit;
        if (cur_len < WORD_LEN) begin
            cur_word[cur_len] = ch;
            cur_len++;
        end else begin
            cur_clipped = 1'b1;
        end
        if (last) begin
            r = '0;
            if (table_fill >= TABLE_DEPTH) begin
                r.stopped = 1'b1;
            end else begin
                hit = table_fill;
                for (int i = table_fill - 1; i >= 0; i--)
                    if (table_words[i] == cur_word)
                        hit = i;
                if (hit < table_fill) begin
                    if (table_counts[hit] != COUNT_MAX)
                        table_counts[hit] = table_counts[hit] + count_t'(1);
                end else begin
                    table_words[hit]  = cur_word;
                    table_counts[hit] = count_t'(1);
                    r.is_new          = 1'b1;
                    table_fill++;
                end
                r.position = hit[7:0];
                r.count    = table_counts[hit];
            end
            r.truncated = cur_clipped;
            expected_tallies.push_back(r);
            cur_word    = '0;
            cur_len     = 0;
            cur_clipped = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            cur_word    = '0;
            cur_len     = 0;
            cur_clipped = 1'b0;
            table_fill  = 0;
            expected_tallies.delete();
            pending     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.position  = m_tdata[7:0];
                got.count     = m_tdata[39:8];
                got.is_new    = m_tuser[0];
                got.stopped   = m_tuser[1];
                got.truncated = m_tuser[2];
                if (expected_tallies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, position %0h count %0h flags %b",
                             $time, got.position, got.count, m_tuser);
                end else begin
                    want = expected_tallies.pop_front();
                    if (got.position !== want.position)
                        flag_field("position", 40'(want.position), 40'(got.position));
                    if (got.count !== want.count)
                        flag_field("count", 40'(want.count), 40'(got.count));
                    if (got.is_new !== want.is_new)
                        flag_field("is_new", 40'(want.is_new), 40'(got.is_new));
                    if (got.stopped !== want.stopped)
                        flag_field("stopped", 40'(want.stopped), 40'(got.stopped));
                    if (got.truncated !== want.truncated)
                        flag_field("truncated", 40'(want.truncated), 40'(got.truncated));
                end
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
            pending = expected_tallies.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import wftt_pkg::*;

    localparam int LONG_WORD_LEN   = 48;              // longest word sent
    localparam int VOCAB_SLOTS     = 64;              // words kept for repeats
    localparam int PHASE_ITEMS     = 100;             // characters per idling phase
    localparam int HOLD_CYCLES     = 1500;            // receiver hold-off, several lookups long
    localparam int DRAIN_CYCLES    = TABLE_DEPTH + 16; // one full lookup and then some
    localparam int POST_FULL_WORDS = 10;              // words sent once the table is full

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] position, [39:8] count
    logic [2:0]  m_tuser;   // [0] is_new, [1] stopped, [2] truncated

    int errors;
    int pending;

    // idling odds in percent, changed per phase
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;

    // word under construction
    logic [7:0] word_chars [LONG_WORD_LEN];
    int         word_len;

    // words already sent, picked again for matches
    logic [7:0] vocab_chars [VOCAB_SLOTS][LONG_WORD_LEN];
    int         vocab_len   [VOCAB_SLOTS];
    int         vocab_n;

    // fresh words start with serial[7:0], so 256 of them are all distinct
    // and are sure to fill the table
    int serial;
    int chars_sent;

    word_frequency_tally_table_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    word_tally_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one character and hold it until taken. Idle gaps come first so
    // valid never drops and rises again in the same step.
    task automatic push_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Send the word in word_chars and keep it for later repeats.
    task automatic send_word();
        int slot;
        for (int i = 0; i < word_len; i++)
            push_char(word_chars[i], i == word_len - 1);
        if (vocab_n < VOCAB_SLOTS)
        begin
            slot = vocab_n;
            vocab_n++;
        end
        else
        begin
            slot = $urandom_range(0, VOCAB_SLOTS - 1);
        end
        for (int i = 0; i < LONG_WORD_LEN; i++)
            vocab_chars[slot][i] = word_chars[i];
        vocab_len[slot] = word_len;
    endtask

    // Short directed word, first character in the low byte.
    task automatic directed_word(input int n, input logic [31:0] bytes);
        word_len = n;
        for (int i = 0; i < n; i++)
            word_chars[i] = bytes[8*i +: 8];
        send_word();
    endtask

    task automatic long_word();
        word_len = $urandom_range(WORD_LEN + 1, LONG_WORD_LEN);
        for (int i = 0; i < word_len; i++)
            word_chars[i] = 8'($urandom_range(0, 255));
        send_word();
    endtask

    // One-character fresh word, fills the table quickly.
    task automatic fill_word();
        word_len      = 1;
        word_chars[0] = serial[7:0];
        serial++;
        send_word();
    endtask

    // Mostly new short words, a good share of repeats, a few overlong ones.
    task automatic random_word();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 55 || vocab_n == 0)
        begin
            word_len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            word_chars[0] = serial[7:0];
            serial++;
            for (int i = 1; i < word_len; i++)
                word_chars[i] = 8'($urandom_range(0, 255));
            send_word();
        end
        else if (pick < 93)
        begin
            k = $urandom_range(0, vocab_n - 1);
            word_len = vocab_len[k];
            for (int i = 0; i < LONG_WORD_LEN; i++)
                word_chars[i] = vocab_chars[k][i];
            if (word_len > WORD_LEN)
            begin
                // dropped tail differs, still the same word
                word_len = $urandom_range(WORD_LEN + 1, LONG_WORD_LEN);
                for (int i = WORD_LEN; i < word_len; i++)
                    word_chars[i] = 8'($urandom_range(0, 255));
            end
            else if (word_len < WORD_LEN && $urandom_range(0, 9) == 0)
            begin
                // trailing zero looks like padding, so this still matches
                word_chars[word_len] = 8'h00;
                word_len++;
            end
            send_word();
        end
        else
        begin
            long_word();
        end
    endtask

    // Sender pause: drop valid, then wait until every tally is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        s_tlast     <= 1'b0;
        hold_req    = 1'b0;
        vocab_n     = 0;
        serial      = 0;
        chars_sent  = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 83;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first hit and repeat, trailing zero equal to padding,
        // character extremes, the all-zero word, near misses.
        directed_word(1, 32'h0000_0041);
        directed_word(1, 32'h0000_0041);
        directed_word(2, 32'h0000_0041);
        directed_word(1, 32'h0000_00ff);
        directed_word(1, 32'h0000_0000);
        directed_word(2, 32'h0000_0000);
        directed_word(3, 32'h0001_7f80);
        directed_word(3, 32'h0001_807f);
        directed_word(2, 32'h0000_4241);
        directed_word(3, 32'h0001_7f80);

        // Phase 1: slow receiver
        chars_sent = 0;
        while (chars_sent < PHASE_ITEMS)
            random_word();
        drain();

        // Phase 2: slow sender
        tx_idle_pct = 83;
        rx_idle_pct = 23;
        chars_sent = 0;
        while (chars_sent < PHASE_ITEMS)
            random_word();
        drain();

        // Phase 3: no idling, opens with the receiver hold-off so the block
        // backs up into its input. Keep going until the table is full.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        while (serial < TABLE_DEPTH)
            fill_word();
        // table full from here: stopped, also with truncation
        long_word();
        repeat (POST_FULL_WORDS) random_word();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
